// ===== design/tgrc_pkg.sv =====
`timescale 1ns / 1ps
package tgrc_pkg;
  localparam int ARM_COUNT_DEF = 2;
  localparam int SECTOR_COUNT_DEF = 4;
  localparam int TOWERS_ALONG_Z_DEF = 96;
  localparam int TOWERS_ALONG_Y_DEF = 48;
  localparam int RUN_LIST_DEPTH_DEF = 64;
  localparam int FACTOR_FRACTION_BITS_DEF = 14;
  localparam logic [23:0] MAX_RUN_DISTANCE_RESET = 24'd500;
  localparam logic [1:0] MODE_LOAD_TOWER = 2'd0;
  localparam logic [1:0] MODE_LOAD_RUN = 2'd1;
  localparam logic [1:0] MODE_CORRECT = 2'd2;
endpackage

// ===== design/tgrc_ram.sv =====
`timescale 1ns / 1ps
module tgrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/tower_gain_run_calibration_top.sv =====
`timescale 1ns / 1ps
// Tower gain and run factor calibration of calorimeter hits.
// The input channel (in_valid, in_stall) carries one item per transfer: a tower
// gain load, a run factor load or a hit to correct. The output channel
// (out_valid, out_stall) carries one corrected hit per correction item; loads
// give nothing. The configuration channel (cfg_valid, cfg_ready) writes the
// maximum run distance and is always ready.
// A load passes through S_READ and goes back to idle. A correction of an invalid
// tower passes through S_READ, S_CHECK and S_OUT; one that hits the per-sector
// run cache goes from S_CHECK through S_GAIN, S_MLO and S_MHI to S_OUT.
// A cache miss walks the sector's run list one entry per cycle through the list
// memory read port, and when an entry matches, its factor is read back in S_BEST.
// The shared 32 by 32 multiplier forms the gain product and then two partial
// products of the energy scaling, one per cycle.
// At reset the run counts clear, each cache holds run 0 with factor 1.0, and a
// clearing pass walks the tower valid memory, one entry per cycle, over all
// ARM_COUNT*SECTOR_COUNT*TOWERS_ALONG_Z*TOWERS_ALONG_Y entries (36864 by
// default), during which no item is taken. While the receiver stalls, the result
// is held in the output register and no further item is taken.
module tower_gain_run_calibration_top #(
  parameter int ARM_COUNT = tgrc_pkg::ARM_COUNT_DEF,
  parameter int SECTOR_COUNT = tgrc_pkg::SECTOR_COUNT_DEF,
  parameter int TOWERS_ALONG_Z = tgrc_pkg::TOWERS_ALONG_Z_DEF,
  parameter int TOWERS_ALONG_Y = tgrc_pkg::TOWERS_ALONG_Y_DEF,
  parameter int RUN_LIST_DEPTH = tgrc_pkg::RUN_LIST_DEPTH_DEF,
  parameter int FACTOR_FRACTION_BITS = tgrc_pkg::FACTOR_FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic               arm,
  input  logic [1:0]         sector,
  input  logic [6:0]         tower_z,
  input  logic [5:0]         tower_y,
  input  logic [17:0]        factor,
  input  logic               entry_valid,
  input  logic [23:0]        run_number,
  input  logic signed [31:0] energy_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] energy_out,
  output logic               tower_applied,
  output logic               run_matched,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data
);
  localparam int GROUPS = ARM_COUNT * SECTOR_COUNT;
  localparam int TOWERS = GROUPS * TOWERS_ALONG_Z * TOWERS_ALONG_Y;
  localparam int TW = (TOWERS > 1) ? $clog2(TOWERS) : 1;
  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int LW = (RUN_LIST_DEPTH > 1) ? $clog2(RUN_LIST_DEPTH) : 1;
  localparam int CW = $clog2(RUN_LIST_DEPTH + 1);
  localparam int RD = GROUPS * RUN_LIST_DEPTH;
  localparam int RW = (RD > 1) ? $clog2(RD) : 1;
  localparam int SH = 2 * FACTOR_FRACTION_BITS;
  localparam logic [17:0] FACTOR_ONE = 18'(1 << FACTOR_FRACTION_BITS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_LAST  = 4'd5;
  localparam logic [3:0] S_GAIN  = 4'd6;
  localparam logic [3:0] S_MLO   = 4'd7;
  localparam logic [3:0] S_MHI   = 4'd8;
  localparam logic [3:0] S_SAT   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_BEST  = 4'd11;

  logic [3:0] state;
  logic [23:0] max_run_distance;
  logic [TW-1:0] clr_addr;

  // Latched item.
  logic [1:0]  r_mode;
  logic [TW-1:0] r_tower;
  logic [GW-1:0] r_group;
  logic        r_in_range;
  logic        r_group_ok;
  logic [17:0] r_factor;
  logic        r_entry_valid;
  logic [23:0] r_run;
  logic [31:0] r_energy;

  // Per-group state.
  logic [CW-1:0] run_count [GROUPS];
  logic [23:0] cached_run [GROUPS];
  logic [17:0] cached_factor [GROUPS];

  // Scan and arithmetic registers.
  logic [CW-1:0] scan_n;
  logic [23:0] best_d;
  logic [LW-1:0] best_idx;
  logic        found;
  logic [17:0] run_f;
  logic        hit;
  logic [35:0] prod_p;
  logic        neg;
  logic [31:0] mag;
  logic [63:0] acc_lo;
  logic [63:0] mul_out;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  // Address computation for the incoming item.
  logic in_group_ok;
  logic in_range;
  logic [GW-1:0] in_group;
  logic [TW-1:0] in_tower;
  always_comb begin
    in_group_ok = (32'(arm) < ARM_COUNT) && (32'(sector) < SECTOR_COUNT);
    in_range = in_group_ok && (32'(tower_z) < TOWERS_ALONG_Z) &&
               (32'(tower_y) < TOWERS_ALONG_Y);
    in_group = GW'(32'(arm) * SECTOR_COUNT + 32'(sector));
    in_tower = TW'((32'(in_group) * TOWERS_ALONG_Z + 32'(tower_z)) * TOWERS_ALONG_Y
               + 32'(tower_y));
  end

  logic accept;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Tower memories.
  logic tv_we;
  logic [TW-1:0] tv_waddr;
  logic tv_wdata;
  logic tv_rdata;
  logic tg_we;
  logic [17:0] tg_rdata;
  assign tv_we = (state == S_CLEAR) ||
                 (state == S_READ && r_mode == tgrc_pkg::MODE_LOAD_TOWER && r_in_range);
  assign tv_waddr = (state == S_CLEAR) ? clr_addr : r_tower;
  assign tv_wdata = (state == S_CLEAR) ? 1'b0 : r_entry_valid;
  assign tg_we = (state == S_READ && r_mode == tgrc_pkg::MODE_LOAD_TOWER && r_in_range);

  tgrc_ram #(.WIDTH(1), .DEPTH(TOWERS)) u_tower_valid (
    .clk(clk), .we(tv_we), .waddr(tv_waddr), .wdata(tv_wdata),
    .raddr(r_tower), .rdata(tv_rdata));
  tgrc_ram #(.WIDTH(18), .DEPTH(TOWERS)) u_tower_gain (
    .clk(clk), .we(tg_we), .waddr(r_tower), .wdata(r_factor),
    .raddr(r_tower), .rdata(tg_rdata));

  // Run list memory: run number and factor in one word.
  logic rl_we;
  logic [RW-1:0] rl_waddr;
  logic [RW-1:0] rl_raddr;
  logic [LW-1:0] rl_ridx;
  logic [41:0] rl_rdata;
  logic [CW-1:0] grp_count;
  assign grp_count = run_count[r_group];
  assign rl_we = (state == S_READ) && (r_mode == tgrc_pkg::MODE_LOAD_RUN) && r_entry_valid
                 && r_group_ok && (32'(grp_count) < RUN_LIST_DEPTH);
  assign rl_waddr = RW'(32'(r_group) * RUN_LIST_DEPTH + 32'(grp_count));
  always_comb begin
    if (state == S_BEST) begin
      rl_ridx = best_idx;
    end else begin
      rl_ridx = LW'(scan_n - CW'(1));
    end
  end
  assign rl_raddr = RW'(32'(r_group) * RUN_LIST_DEPTH + 32'(rl_ridx));

  tgrc_ram #(.WIDTH(42), .DEPTH(RD)) u_run_list (
    .clk(clk), .we(rl_we), .waddr(rl_waddr), .wdata({r_run, r_factor}),
    .raddr(rl_raddr), .rdata(rl_rdata));

  // Distance of the list entry that was read last cycle.
  logic [23:0] ln;
  logic [23:0] run_gap;
  assign ln = rl_rdata[41:18];
  assign run_gap = (ln > r_run) ? (ln - r_run) : (r_run - ln);

  // Shared multiplier.
  always_comb begin
    unique case (state)
      S_GAIN:  begin mul_a = {14'd0, tg_rdata}; mul_b = {14'd0, run_f}; end
      S_MLO:   begin mul_a = mag; mul_b = prod_p[31:0]; end
      default: begin mul_a = mag; mul_b = {28'd0, prod_p[35:32]}; end
    endcase
    mul_out = 64'(mul_a) * 64'(mul_b);
  end

  // Sum of partial products and saturation.
  logic [67:0] full;
  logic [67:0] shifted;
  logic [31:0] limit;
  logic [31:0] res;
  always_comb begin
    full = 68'(acc_lo) + (68'(mul_out) << 32);
    shifted = full >> SH;
    limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    res = (shifted > 68'(limit)) ? limit : shifted[31:0];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      max_run_distance <= tgrc_pkg::MAX_RUN_DISTANCE_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < GROUPS; i++) begin
        run_count[i] <= '0;
        cached_run[i] <= '0;
        cached_factor[i] <= FACTOR_ONE;
      end
    end else begin
      if (cfg_valid) begin
        max_run_distance <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + TW'(1);
          if (32'(clr_addr) == TOWERS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            r_mode <= mode;
            r_tower <= in_tower;
            r_group <= in_group;
            r_in_range <= in_range;
            r_group_ok <= in_group_ok;
            r_factor <= factor;
            r_entry_valid <= entry_valid;
            r_run <= run_number;
            r_energy <= energy_in;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (rl_we) begin
            run_count[r_group] <= grp_count + CW'(1);
          end
          state <= (r_mode == tgrc_pkg::MODE_CORRECT) ? S_CHECK : S_IDLE;
          scan_n <= grp_count;
          best_d <= max_run_distance;
          found <= 1'b0;
          neg <= r_energy[31];
          mag <= r_energy[31] ? (32'd0 - r_energy) : r_energy;
        end
        S_CHECK: begin
          if (!(r_in_range && tv_rdata)) begin
            energy_out <= r_energy;
            tower_applied <= 1'b0;
            run_matched <= 1'b0;
            state <= S_OUT;
          end else if (r_run == cached_run[r_group]) begin
            run_f <= cached_factor[r_group];
            hit <= 1'b1;
            state <= S_GAIN;
          end else if (scan_n == '0) begin
            run_f <= FACTOR_ONE;
            hit <= 1'b0;
            state <= S_GAIN;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Read issued for entry scan_n-1; step down.
          scan_n <= scan_n - CW'(1);
          state <= (scan_n == CW'(1)) ? S_LAST : S_SCAN;
          if (scan_n != grp_count) begin
            if (run_gap < best_d) begin
              best_d <= run_gap;
              best_idx <= LW'(scan_n);
              found <= 1'b1;
            end
          end
        end
        S_LAST: begin
          if (run_gap < best_d) begin
            best_idx <= '0;
            found <= 1'b1;
            state <= S_BEST;
          end else if (found) begin
            state <= S_BEST;
          end else begin
            run_f <= FACTOR_ONE;
            hit <= 1'b0;
            state <= S_GAIN;
          end
          scan_n <= '0;
        end
        S_BEST: begin
          // Wait for the registered read of the winning entry.
          if (scan_n == '0) begin
            scan_n <= CW'(1);
          end else begin
            cached_run[r_group] <= rl_rdata[41:18];
            cached_factor[r_group] <= rl_rdata[17:0];
            run_f <= rl_rdata[17:0];
            hit <= 1'b1;
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          prod_p <= mul_out[35:0];
          state <= S_MLO;
        end
        S_MLO: begin
          acc_lo <= mul_out;
          state <= S_MHI;
        end
        S_MHI: begin
          energy_out <= neg ? (32'd0 - res) : res;
          tower_applied <= 1'b1;
          run_matched <= hit;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== bench/tower_gain_run_calibration_top_tb.sv =====
`timescale 1ns / 1ps
module tower_gain_run_calibration_top_tb;

  localparam int GROUPS = tgrc_pkg::ARM_COUNT_DEF * tgrc_pkg::SECTOR_COUNT_DEF;
  localparam int TOWERS = GROUPS * tgrc_pkg::TOWERS_ALONG_Z_DEF *
                          tgrc_pkg::TOWERS_ALONG_Y_DEF;
  localparam int LIST_DEPTH = tgrc_pkg::RUN_LIST_DEPTH_DEF;
  localparam logic [17:0] GAIN_ONE = 18'(1 << tgrc_pkg::FACTOR_FRACTION_BITS_DEF);
  localparam int STALL_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [1:0]         mode;
    logic               arm;
    logic [1:0]         sector;
    logic [6:0]         tower_z;
    logic [5:0]         tower_y;
    logic [17:0]        factor;
    logic               entry_valid;
    logic [23:0]        run_number;
    logic signed [31:0] energy_in;
  } hit_item_t;

  typedef struct {
    logic signed [31:0] energy_out;
    logic               tower_applied;
    logic               run_matched;
  } corrected_hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = tgrc_pkg::MODE_LOAD_TOWER;
  logic arm = 1'b0;
  logic [1:0] sector = 2'd0;
  logic [6:0] tower_z = 7'd0;
  logic [5:0] tower_y = 6'd0;
  logic [17:0] factor = 18'd0;
  logic entry_valid = 1'b0;
  logic [23:0] run_number = 24'd0;
  logic signed [31:0] energy_in = 32'sd0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] energy_out;
  logic tower_applied;
  logic run_matched;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [23:0] cfg_data = 24'd0;

  tower_gain_run_calibration_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .arm(arm), .sector(sector), .tower_z(tower_z), .tower_y(tower_y),
    .factor(factor), .entry_valid(entry_valid), .run_number(run_number),
    .energy_in(energy_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .energy_out(energy_out), .tower_applied(tower_applied), .run_matched(run_matched),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the calibration state.
  logic [23:0] run_window;
  logic [17:0] gain_mem [TOWERS];
  bit          gain_ok [TOWERS];
  logic [23:0] list_run [GROUPS][LIST_DEPTH];
  logic [17:0] list_gain [GROUPS][LIST_DEPTH];
  int          list_len [GROUPS];
  logic [23:0] last_run [GROUPS];
  logic [17:0] last_gain [GROUPS];

  hit_item_t      pending_items[$];
  corrected_hit_t expected_hits[$];
  int  fail_count = 0;
  int  hits_seen = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_idle_on = 1'b0;
  bit  in_taken = 1'b0;
  int  gap_left = 0;
  int  rx_wait = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  quiet_cycles = 0;

  // Signed energy times unsigned gain product, truncated toward zero, saturated.
  function automatic logic signed [31:0] scale_energy(logic signed [31:0] e,
                                                      logic [35:0] p);
    logic signed [71:0] prod;
    logic signed [71:0] q;
    prod = $signed(e) * $signed({1'b0, p});
    if (prod < 0) q = -((-prod) >>> (2 * tgrc_pkg::FACTOR_FRACTION_BITS_DEF));
    else q = prod >>> (2 * tgrc_pkg::FACTOR_FRACTION_BITS_DEF);
    if (q > 72'sd2147483647) return 32'sh7FFFFFFF;
    if (q < -72'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic void reset_shadow();
    run_window = tgrc_pkg::MAX_RUN_DISTANCE_RESET;
    for (int t = 0; t < TOWERS; t++) gain_ok[t] = 1'b0;
    for (int g = 0; g < GROUPS; g++) begin
      list_len[g] = 0;
      last_run[g] = 24'd0;
      last_gain[g] = GAIN_ONE;
    end
  endfunction

  // Update the shadow state for one accepted item and, for a correction item, queue its corrected hit.
  function automatic void apply_item(hit_item_t it);
    int g;
    int t;
    bit in_range;
    logic [17:0] rf;
    bit matched;
    int best;
    logic [23:0] best_d;
    logic [23:0] d;
    corrected_hit_t r;
    g = it.arm * tgrc_pkg::SECTOR_COUNT_DEF + it.sector;
    in_range = (it.tower_z < tgrc_pkg::TOWERS_ALONG_Z_DEF) &&
               (it.tower_y < tgrc_pkg::TOWERS_ALONG_Y_DEF);
    t = (g * tgrc_pkg::TOWERS_ALONG_Z_DEF + it.tower_z) * tgrc_pkg::TOWERS_ALONG_Y_DEF
        + it.tower_y;
    case (it.mode)
      tgrc_pkg::MODE_LOAD_TOWER: begin
        if (in_range) begin
          gain_mem[t] = it.factor;
          gain_ok[t] = it.entry_valid;
        end
      end
      tgrc_pkg::MODE_LOAD_RUN: begin
        if (it.entry_valid && list_len[g] < LIST_DEPTH) begin
          list_run[g][list_len[g]] = it.run_number;
          list_gain[g][list_len[g]] = it.factor;
          list_len[g]++;
        end
      end
      tgrc_pkg::MODE_CORRECT: begin
        if (in_range && gain_ok[t]) begin
          if (it.run_number == last_run[g]) begin
            rf = last_gain[g];
            matched = 1'b1;
          end else begin
            // Scan from the newest entry, so a tie keeps the later one.
            best = -1;
            best_d = run_window;
            for (int k = list_len[g] - 1; k >= 0; k--) begin
              d = list_run[g][k] > it.run_number ? list_run[g][k] - it.run_number
                                                 : it.run_number - list_run[g][k];
              if (d < best_d) begin
                best_d = d;
                best = k;
              end
            end
            if (best < 0) begin
              rf = GAIN_ONE;
              matched = 1'b0;
            end else begin
              last_run[g] = list_run[g][best];
              last_gain[g] = list_gain[g][best];
              rf = last_gain[g];
              matched = 1'b1;
            end
          end
          r.energy_out = scale_energy(it.energy_in, 36'(gain_mem[t]) * 36'(rf));
          r.tower_applied = 1'b1;
          r.run_matched = matched;
        end else begin
          r.energy_out = it.energy_in;
          r.tower_applied = 1'b0;
          r.run_matched = 1'b0;
        end
        expected_hits.insert(expected_hits.size(), r);
      end
      default: ;
    endcase
  endfunction

  // Input side: record each transfer and predict its result.
  always @(posedge clk) begin
    hit_item_t it;
    in_taken <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall) begin
      it.mode = mode;
      it.arm = arm;
      it.sector = sector;
      it.tower_z = tower_z;
      it.tower_y = tower_y;
      it.factor = factor;
      it.entry_valid = entry_valid;
      it.run_number = run_number;
      it.energy_in = energy_in;
      apply_item(it);
    end
  end

  // Driver: presents queued items, with a random gap between items when tx_idle_on is set.
  always @(negedge clk) begin
    hit_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() > 0 && gap_left == 0) begin
        it = pending_items.pop_front();
        mode <= it.mode;
        arm <= it.arm;
        sector <= it.sector;
        tower_z <= it.tower_z;
        tower_y <= it.tower_y;
        factor <= it.factor;
        entry_valid <= it.entry_valid;
        run_number <= it.run_number;
        energy_in <= it.energy_in;
        in_valid <= 1'b1;
        gap_left <= tx_idle_on ? $urandom_range(0, 12) : 0;
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // Monitor: checks each output transfer against the oldest prediction.
  always @(posedge clk) begin
    corrected_hit_t e;
    if (!rst && out_valid && !out_stall) begin
      hits_seen <= hits_seen + 1;
      rx_wait <= rx_idle_on ? $urandom_range(0, 12) : 0;
      if (expected_hits.size() == 0) begin
        $error("unexpected result: energy_out %0d", energy_out);
        fail_count++;
      end else begin
        e = expected_hits.pop_front();
        if (energy_out !== e.energy_out) begin
          $error("energy_out: expected %0d, actual %0d", e.energy_out, energy_out);
          fail_count++;
        end
        if (tower_applied !== e.tower_applied) begin
          $error("tower_applied: expected %0d, actual %0d", e.tower_applied, tower_applied);
          fail_count++;
        end
        if (run_matched !== e.run_matched) begin
          $error("run_matched: expected %0d, actual %0d", e.run_matched, run_matched);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off once results are flowing.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b1;
    end else if (!hold_done && hits_seen >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any transfer; covers the clearing pass after reset.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus.
  logic        pool_arm [32];
  logic [1:0]  pool_sector [32];
  logic [6:0]  pool_z [32];
  logic [5:0]  pool_y [32];
  logic [23:0] recent_run;

  function automatic hit_item_t make_item(logic [1:0] m, int p, logic [17:0] f,
                                          logic v, logic [23:0] r, logic signed [31:0] e);
    hit_item_t it;
    it.mode = m;
    it.arm = pool_arm[p];
    it.sector = pool_sector[p];
    it.tower_z = pool_z[p];
    it.tower_y = pool_y[p];
    it.factor = f;
    it.entry_valid = v;
    it.run_number = r;
    it.energy_in = e;
    return it;
  endfunction

  // Append one item to the pending list of the driver.
  function automatic void queue_item(hit_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic logic signed [31:0] pick_energy();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom());
      default: return $signed(32'($urandom_range(0, 2000000)) - 32'sd1000000);
    endcase
  endfunction

  function automatic logic [17:0] pick_factor();
    case ($urandom_range(0, 5))
      0: return 18'($urandom());
      1: return 18'h3FFFF;
      default: return 18'($urandom_range(8000, 40000));
    endcase
  endfunction

  task automatic queue_random(int count);
    hit_item_t it;
    int p;
    int roll;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 31);
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
        it = make_item(tgrc_pkg::MODE_LOAD_TOWER, p, pick_factor(),
                       $urandom_range(0, 5) != 0, 24'($urandom()), $signed($urandom()));
      end else if (roll < 37) begin
        it = make_item(tgrc_pkg::MODE_LOAD_RUN, p, pick_factor(), $urandom_range(0, 7) != 0,
                       24'($urandom_range(1000, 3000)), $signed($urandom()));
        // Most run loads go to one sector so its list fills up.
        if ($urandom_range(0, 9) < 6) begin
          it.arm = 1'b0;
          it.sector = 2'd0;
        end
        if ($urandom_range(0, 9) == 0) it.run_number = 24'($urandom());
      end else begin
        it = make_item(tgrc_pkg::MODE_CORRECT, p, 18'($urandom()), 1'($urandom_range(0, 1)),
                       recent_run, pick_energy());
        if ($urandom_range(0, 9) == 0) it.run_number = 24'($urandom());
        else if ($urandom_range(0, 2) == 0)
          it.run_number = 24'($urandom_range(400, 3600));
        recent_run = it.run_number;
      end
      // Occasional out-of-range addresses and ignored mode.
      if ($urandom_range(0, 24) == 0) it.tower_z = 7'($urandom_range(96, 127));
      if ($urandom_range(0, 24) == 0) it.tower_y = 6'($urandom_range(48, 63));
      if ($urandom_range(0, 49) == 0) it.mode = 2'd3;
      queue_item(it);
    end
  endtask

  task automatic write_run_window(logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    run_window = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [23:0] windows [6];
    hit_item_t it;
    reset_shadow();
    for (int p = 0; p < 32; p++) begin
      pool_arm[p] = 1'($urandom_range(0, 1));
      pool_sector[p] = 2'($urandom_range(0, 3));
      pool_z[p] = 7'($urandom_range(0, 95));
      pool_y[p] = 6'($urandom_range(0, 47));
    end
    pool_z[0] = 7'd95;
    pool_y[0] = 6'd47;
    pool_arm[0] = 1'b1;
    pool_sector[0] = 2'd3;
    pool_z[1] = 7'd0;
    pool_y[1] = 6'd0;
    pool_arm[1] = 1'b0;
    pool_sector[1] = 2'd0;
    recent_run = 24'd1000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 1, 18'd0, 1'b1, 24'd0, 32'sd1000));
    queue_item(make_item(tgrc_pkg::MODE_LOAD_TOWER, 1, GAIN_ONE, 1'b1, 24'd0, 32'sd0));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 1, 18'd0, 1'b0, 24'd0, 32'sh7FFFFFFF));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 1, 18'd0, 1'b0, 24'd0, 32'sh80000000));
    queue_item(make_item(tgrc_pkg::MODE_LOAD_TOWER, 0, 18'h3FFFF, 1'b1, 24'd0, 32'sd0));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 0, 18'd0, 1'b0, 24'd0, 32'sh7FFFFFFF));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 0, 18'd0, 1'b0, 24'd0, 32'sh80000000));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 0, 18'd0, 1'b0, 24'd0, -32'sd1));
    queue_item(make_item(tgrc_pkg::MODE_LOAD_RUN, 1, 18'h3FFFF, 1'b0, 24'd1100, 32'sd0));
    queue_item(make_item(tgrc_pkg::MODE_LOAD_RUN, 1, 18'd20000, 1'b1, 24'd1000, 32'sd0));
    queue_item(make_item(tgrc_pkg::MODE_LOAD_RUN, 1, 18'd30000, 1'b1, 24'd1200, 32'sd0));
    queue_item(make_item(tgrc_pkg::MODE_LOAD_RUN, 1, 18'h3FFFF, 1'b1, 24'hFFFFFF, 32'sd0));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 1, 18'd0, 1'b0, 24'd1100, 32'sd65536));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 1, 18'd0, 1'b0, 24'd1100, -32'sd65537));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 1, 18'd0, 1'b0, 24'd990, 32'sd65536));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 1, 18'd0, 1'b0, 24'd8000, 32'sd65536));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 1, 18'd0, 1'b0, 24'hFFFFFE, 32'sd65536));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 2, 18'd0, 1'b0, 24'd0, 32'sd12345));
    it = make_item(tgrc_pkg::MODE_CORRECT, 0, 18'd0, 1'b0, 24'd0, 32'sd777);
    it.tower_z = 7'd127;
    queue_item(it);
    it = make_item(tgrc_pkg::MODE_LOAD_TOWER, 1, 18'd5, 1'b1, 24'd0, 32'sd0);
    it.tower_y = 6'd63;
    queue_item(it);
    it.mode = 2'd3;
    queue_item(it);
    queue_item(make_item(tgrc_pkg::MODE_LOAD_TOWER, 1, 18'd0, 1'b0, 24'd0, 32'sd0));
    queue_item(make_item(tgrc_pkg::MODE_CORRECT, 1, 18'd0, 1'b0, 24'd1100, 32'sd65536));
    drain();

    // Random phases over several distances; the drain between them is the
    // sender pause until every result has arrived.
    windows[0] = 24'd1;
    windows[1] = 24'hFFFFFF;
    windows[2] = 24'd500;
    windows[3] = 24'($urandom_range(2, 2000));
    windows[4] = 24'($urandom());
    windows[5] = 24'd300;
    for (int ph = 0; ph < 6; ph++) begin
      write_run_window(windows[ph]);
      tx_idle_on = ph % 3 != 0;
      rx_idle_on = ph % 2 == 0;
      queue_random(180);
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tgrc_pkg.sv
design/tgrc_ram.sv
design/tower_gain_run_calibration_top.sv
bench/tower_gain_run_calibration_top_tb.sv
